@@ hw/rtl/cpl_pkg.sv @@
package cpl_pkg;

    localparam int unsigned NUM_SLOTS = 4;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned DIV_STEPS = VAL_W;

    typedef logic signed [VAL_W-1:0] q88_t;

    // x sits in the upper half, matching the register layout
    typedef struct packed {
        q88_t x;
        q88_t y;
    } point_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PARAM_MIN      = 3'd0,
        REG_PARAM_MAX      = 3'd1,
        REG_MAPPING_ENABLE = 3'd2,
        REG_POINT_COUNT    = 3'd3,
        REG_POINT_ZERO     = 3'd4,
        REG_POINT_ONE      = 3'd5,
        REG_POINT_TWO      = 3'd6,
        REG_POINT_THREE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        q88_t                        param_min;
        q88_t                        param_max;
        logic                        mapping_enable;
        logic [CNT_W-1:0]            point_count;
        point_t [NUM_SLOTS-1:0]      points;
    } cfg_t;

    // Item moving through the divider: rem is the partial remainder, work
    // holds the dividend bits still to come and collects quotient bits.
    typedef struct packed {
        q88_t             clamped;
        q88_t             base;
        logic             interp;
        logic             neg;
        logic [VAL_W-1:0] den;
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] work;
    } item_t;

endpackage

@@ hw/rtl/cpl_regs.sv @@
module cpl_regs
    import cpl_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1 << FRAC_BITS);

    // bounds [0, 1.0], mapping off, empty curve
    localparam cfg_t CFG_RESET = cfg_t'({{VAL_W{1'b0}}, ONE_VAL, 1'b0, {CNT_W{1'b0}},
                                         {(NUM_SLOTS * 2 * VAL_W){1'b0}}});

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PARAM_MIN:      cfg_reg.param_min      <= cfg_wdata[VAL_W-1:0];
                REG_PARAM_MAX:      cfg_reg.param_max      <= cfg_wdata[VAL_W-1:0];
                REG_MAPPING_ENABLE: cfg_reg.mapping_enable <= cfg_wdata[0];
                REG_POINT_COUNT:    cfg_reg.point_count    <= cfg_wdata[CNT_W-1:0];
                REG_POINT_ZERO:     cfg_reg.points[0]      <= cfg_wdata;
                REG_POINT_ONE:      cfg_reg.points[1]      <= cfg_wdata;
                REG_POINT_TWO:      cfg_reg.points[2]      <= cfg_wdata;
                REG_POINT_THREE:    cfg_reg.points[3]      <= cfg_wdata;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/cpl_front.sv @@
module cpl_front
    import cpl_pkg::*;
#(
    parameter int MAX_POINTS = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  q88_t  raw_value,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POINTS);

    typedef struct packed {
        q88_t             clamped;
        q88_t             base;
        logic             interp;
        logic             neg;
        logic [VAL_W-1:0] dx;
        logic [VAL_W-1:0] dy_mag;
        logic [VAL_W-1:0] den;
    } seg_t;

    logic  a_vld_reg;
    q88_t  a_clamp_reg;
    q88_t  a_clamp_next;
    q88_t  lim;
    logic  a_ready;

    logic  b_vld_reg;
    seg_t  b_reg;
    seg_t  b_next;
    logic  b_ready;

    logic  c_vld_reg;
    item_t c_reg;
    item_t c_next;
    logic  c_ready;

    logic [CNT_W-1:0] n;
    point_t           p_last;
    point_t           p_lo;
    point_t           p_hi;
    logic [1:0]       sel;
    logic             found;
    logic signed [VAL_W:0] dx_w;
    logic signed [VAL_W:0] dy_w;
    logic signed [VAL_W:0] den_w;
    logic [2*VAL_W-1:0]    mag;

    assign c_ready  = !c_vld_reg || out_ready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    // clamp: upper bound first, then lower bound so that min wins
    always_comb
    begin
        lim          = (raw_value > cfg.param_max) ? cfg.param_max : raw_value;
        a_clamp_next = (lim < cfg.param_min) ? cfg.param_min : lim;
    end

    // segment search
    always_comb
    begin
        n      = (cfg.point_count > MAX_N) ? MAX_N : cfg.point_count;
        p_last = cfg.points[2'(n - CNT_W'(1))];
        found  = 1'b0;
        sel    = '0;
        for (int i = 0; i < MAX_POINTS - 1; i++)
        begin
            if (!found && (CNT_W'(i + 2) <= n) &&
                (a_clamp_reg >= cfg.points[i].x) && (a_clamp_reg <= cfg.points[i + 1].x))
            begin
                found = 1'b1;
                sel   = 2'(i);
            end
        end
        p_lo  = cfg.points[sel];
        p_hi  = cfg.points[2'(sel + 2'd1)];
        dx_w  = {a_clamp_reg[VAL_W-1], a_clamp_reg} - {p_lo.x[VAL_W-1], p_lo.x};
        dy_w  = {p_hi.y[VAL_W-1], p_hi.y} - {p_lo.y[VAL_W-1], p_lo.y};
        den_w = {p_hi.x[VAL_W-1], p_hi.x} - {p_lo.x[VAL_W-1], p_lo.x};

        b_next         = '0;
        b_next.clamped = a_clamp_reg;
        b_next.base    = a_clamp_reg;
        priority if (!cfg.mapping_enable)
        begin
            b_next.base = a_clamp_reg;
        end
        else if (n == CNT_W'(0))
        begin
            b_next.base = '0;
        end
        else if (n == CNT_W'(1) || a_clamp_reg <= cfg.points[0].x)
        begin
            b_next.base = cfg.points[0].y;
        end
        else if (a_clamp_reg >= p_last.x)
        begin
            b_next.base = p_last.y;
        end
        else if (!found)
        begin
            b_next.base = cfg.points[0].y;
        end
        else
        begin
            // equal x gives the interval's first y, no division
            b_next.base   = p_lo.y;
            b_next.interp = (den_w != '0);
            b_next.neg    = dy_w[VAL_W];
            b_next.dx     = dx_w[VAL_W-1:0];
            b_next.dy_mag = dy_w[VAL_W] ? VAL_W'(-dy_w) : dy_w[VAL_W-1:0];
            b_next.den    = den_w[VAL_W-1:0];
        end
    end

    // product of offset and rise; the quotient by den fits 16 bits
    always_comb
    begin
        mag            = b_reg.dx * b_reg.dy_mag;
        c_next.clamped = b_reg.clamped;
        c_next.base    = b_reg.base;
        c_next.interp  = b_reg.interp;
        c_next.neg     = b_reg.neg;
        c_next.den     = b_reg.den;
        c_next.rem     = mag[2*VAL_W-1:VAL_W];
        c_next.work    = mag[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_vld_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_ready)
            begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_clamp_reg <= a_clamp_next;
        end
        if (b_ready && a_vld_reg)
        begin
            b_reg <= b_next;
        end
        if (c_ready && b_vld_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_item  = c_reg;

endmodule

@@ hw/rtl/cpl_div_step.sv @@
module cpl_div_step
    import cpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic             vld_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;
    logic             qbit;

    assign in_ready = !vld_reg || out_ready;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {in_item.rem, in_item.work[VAL_W-1]};
        diff      = trial - {1'b0, in_item.den};
        qbit      = !diff[VAL_W];
        item_next = in_item;
        if (in_item.interp)
        begin
            item_next.rem  = qbit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            item_next.work = {in_item.work[VAL_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

@@ hw/rtl/clamp_piecewise_linear_map.sv @@
// Clamp a signed Q8.8 value to [param_min, param_max] and map it through a piecewise curve.
// Pipeline: 3 front stages, 16 divider stages and 1 output stage; one item per
// cycle while m_tready does not stall, set by the one-bit-per-stage restoring
// divider that runs fully pipelined.
// Reset (rst_n, async, active low) empties the pipe and loads the register
// reset values; no clearing pass, items are taken right after reset.
module clamp_piecewise_linear_map
    import cpl_pkg::*;
#(
    parameter int MAX_POINTS = 4,
    parameter int FRAC_BITS  = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] raw_value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata    // [15:0] clamped_value, [31:16] mapped_value
);

    cfg_t  cfg;

    // divider chain: index 0 is the front output, index DIV_STEPS the last step
    logic  div_vld [0:DIV_STEPS];
    logic  div_rdy [0:DIV_STEPS];
    item_t div_item [0:DIV_STEPS];

    logic  out_vld_reg;
    logic  out_ready;
    q88_t  clamped_reg;
    q88_t  mapped_reg;
    q88_t  mapped_next;
    logic signed [VAL_W:0]   q_signed;
    logic signed [VAL_W+1:0] sum;

    cpl_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // clamp, segment search and product
    cpl_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_value (s_tdata),
        .out_valid (div_vld[0]),
        .out_ready (div_rdy[0]),
        .out_item  (div_item[0])
    );

    // one quotient bit per stage; items that need no division ride along
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        cpl_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_vld[k]),
            .in_ready  (div_rdy[k]),
            .in_item   (div_item[k]),
            .out_valid (div_vld[k + 1]),
            .out_ready (div_rdy[k + 1]),
            .out_item  (div_item[k + 1])
        );
    end

    assign out_ready          = !out_vld_reg || m_tready;
    assign div_rdy[DIV_STEPS] = out_ready;

    // apply the sign of the rise and add to the interval's first y; the
    // result lies between the two breakpoint y values so it fits 16 bits
    always_comb
    begin
        q_signed = div_item[DIV_STEPS].neg ? -$signed({1'b0, div_item[DIV_STEPS].work})
                                           :  $signed({1'b0, div_item[DIV_STEPS].work});
        sum      = (VAL_W + 2)'(div_item[DIV_STEPS].base) + (VAL_W + 2)'(q_signed);
        mapped_next = div_item[DIV_STEPS].interp ? sum[VAL_W-1:0]
                                                 : div_item[DIV_STEPS].base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_vld_reg <= div_vld[DIV_STEPS];
        end
    end

    // hold the result while the sink stalls
    always_ff @(posedge clk)
    begin
        if (out_ready && div_vld[DIV_STEPS])
        begin
            clamped_reg <= div_item[DIV_STEPS].clamped;
            mapped_reg  <= mapped_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {mapped_reg, clamped_reg};

endmodule

@@ hw/rtl/cpl_checker.sv @@
module cpl_checker
    import cpl_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata
);

    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1 << FRAC_BITS);

    q88_t min_reg;
    q88_t max_reg;
    logic en_reg;
    q88_t clamped;
    q88_t mapped;

    assign clamped = m_tdata[15:0];
    assign mapped  = m_tdata[31:16];

    // shadow the bounds and enable from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= ONE_VAL;
            en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PARAM_MIN)
            begin
                min_reg <= cfg_wdata[VAL_W-1:0];
            end
            if (cfg_index == REG_PARAM_MAX)
            begin
                max_reg <= cfg_wdata[VAL_W-1:0];
            end
            if (cfg_index == REG_MAPPING_ENABLE)
            begin
                en_reg <= cfg_wdata[0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while sink is ready");

    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (clamped >= min_reg) && ((clamped <= max_reg) || (clamped == min_reg)))
        else $error("clamped value outside bounds");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !en_reg |-> mapped == clamped)
        else $error("mapped differs from clamped with mapping off");

endmodule

bind clamp_piecewise_linear_map cpl_checker #(.FRAC_BITS(FRAC_BITS)) u_cpl_checker (.*);

@@ sim/clamp_piecewise_linear_map_checker.sv @@
`timescale 1ns / 100ps

module clamp_piecewise_linear_map_checker
    import cpl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] raw_value
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata,   // [15:0] clamped_value, [31:16] mapped_value
    output int               mismatch_count,
    output int               pending_count
);

    localparam int MAX_POINTS = 4;

    // mapped sits in the upper half, as on m_tdata
    typedef struct packed {
        q88_t mapped;
        q88_t clamped;
    } clamp_map_t;

    q88_t             bound_lo;
    q88_t             bound_hi;
    logic             curve_on;
    logic [CNT_W-1:0] curve_len;
    point_t           curve_pts [NUM_SLOTS];

    clamp_map_t       expected_maps [$];

    function automatic clamp_map_t clamp_and_map(input q88_t raw);
        int         v;
        int         c;
        int         m;
        int         n;
        int         k;
        int         xa;
        int         xb;
        int         ya;
        int         yb;
        longint     acc;
        bit         found;
        clamp_map_t r;
        v = raw;
        if (v > int'(bound_hi))
            v = bound_hi;
        c = (v < int'(bound_lo)) ? int'(bound_lo) : v;
        m = c;
        if (curve_on) begin
            n = (int'(curve_len) > MAX_POINTS) ? MAX_POINTS : int'(curve_len);
            if (n == 0)
                m = 0;
            else if (n == 1)
                m = curve_pts[0].y;
            else if (c <= int'(curve_pts[0].x))
                m = curve_pts[0].y;
            else if (c >= int'(curve_pts[n-1].x))
                m = curve_pts[n-1].y;
            else begin
                // no interval holding x falls back to the first y
                m = curve_pts[0].y;
                found = 1'b0;
                for (k = 0; k + 1 < n; k++) begin
                    xa = curve_pts[k].x;
                    xb = curve_pts[k+1].x;
                    ya = curve_pts[k].y;
                    yb = curve_pts[k+1].y;
                    if (!found && c >= xa && c <= xb) begin
                        found = 1'b1;
                        if (xa == xb)
                            m = ya;
                        else begin
                            acc = longint'(c - xa) * longint'(yb - ya);
                            acc = acc / longint'(xb - xa);
                            acc = acc + ya;
                            if (acc > 32767)
                                acc = 32767;
                            if (acc < -32768)
                                acc = -32768;
                            m = int'(acc);
                        end
                    end
                end
            end
        end
        r.clamped = q88_t'(c);
        r.mapped  = q88_t'(m);
        return r;
    endfunction

    always @(posedge clk) begin : watch_channels
        clamp_map_t want;
        clamp_map_t got;
        if (!rst_n) begin
            bound_lo  = '0;
            bound_hi  = q88_t'(256);
            curve_on  = 1'b0;
            curve_len = '0;
            for (int k = 0; k < NUM_SLOTS; k++)
                curve_pts[k] = '0;
            expected_maps.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_index))
                    REG_PARAM_MIN:      bound_lo     = cfg_wdata[15:0];
                    REG_PARAM_MAX:      bound_hi     = cfg_wdata[15:0];
                    REG_MAPPING_ENABLE: curve_on     = cfg_wdata[0];
                    REG_POINT_COUNT:    curve_len    = cfg_wdata[CNT_W-1:0];
                    REG_POINT_ZERO:     curve_pts[0] = cfg_wdata;
                    REG_POINT_ONE:      curve_pts[1] = cfg_wdata;
                    REG_POINT_TWO:      curve_pts[2] = cfg_wdata;
                    REG_POINT_THREE:    curve_pts[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_maps.insert(expected_maps.size(), clamp_and_map(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_maps.size() == 0) begin
                    $display("%0t unexpected item: actual clamped %0d mapped %0d",
                             $time, got.clamped, got.mapped);
                    mismatch_count++;
                end else begin
                    want = expected_maps.pop_front();
                    if (got.clamped !== want.clamped) begin
                        $display("%0t clamped_value: expected %0d, actual %0d",
                                 $time, want.clamped, got.clamped);
                        mismatch_count++;
                    end
                    if (got.mapped !== want.mapped) begin
                        $display("%0t mapped_value: expected %0d, actual %0d",
                                 $time, want.mapped, got.mapped);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = expected_maps.size();
    end

endmodule

@@ sim/clamp_piecewise_linear_map_tb.sv @@
`timescale 1ns / 100ps

module clamp_piecewise_linear_map_tb;
    import cpl_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int LONG_HOLD      = 400;   // receiver hold-off, well past the pipe depth
    localparam int DRAIN_CYCLES   = 40;    // settle time before the final check
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 125;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;

    int               mismatch_count;
    int               pending_count;
    int               idle_cycles;
    int               rx_cycle;
    int               hold_left;
    bit               long_hold_req;

    // Shadow of what was last written, used only to aim the stimulus
    q88_t             cur_min;
    q88_t             cur_max;
    point_t           cur_pts [NUM_SLOTS];

    clamp_piecewise_linear_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    clamp_piecewise_linear_map_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if no item moves for too long
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: step through four stall patterns in turn; a long
    // hold-off is taken when the stimulus asks for one.
    initial
    begin
        m_tready  = 1'b0;
        rx_cycle  = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else begin
                case ((rx_cycle / 128) % 4)
                    0: m_tready <= 1'b1;                          // no stalls
                    1: m_tready <= 1'($urandom_range(0, 1));      // coin flip
                    2: m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: m_tready <= ((rx_cycle % 7) < 4);    // fixed rhythm
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted; return on the falling edge
    // after the accept with tvalid still high.
    task automatic send_item(input logic [15:0] raw);
        s_tdata  <= raw;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // One register write; leaves cfg_we high so writes can run back to back
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    // Write every register. Junk in the unused upper bits of the narrow
    // registers must be dropped by the block.
    task automatic set_cfg(input q88_t mn, input q88_t mx, input logic en,
                           input logic [CNT_W-1:0] cnt,
                           input point_t p0, input point_t p1,
                           input point_t p2, input point_t p3);
        @(negedge clk);
        write_reg(REG_PARAM_MIN,      {16'($urandom), mn});
        write_reg(REG_PARAM_MAX,      {16'($urandom), mx});
        write_reg(REG_MAPPING_ENABLE, {31'($urandom), en});
        write_reg(REG_POINT_COUNT,    {29'($urandom), cnt});
        write_reg(REG_POINT_ZERO,     p0);
        write_reg(REG_POINT_ONE,      p1);
        write_reg(REG_POINT_TWO,      p2);
        write_reg(REG_POINT_THREE,    p3);
        cfg_we     <= 1'b0;
        cur_min    = mn;
        cur_max    = mx;
        cur_pts[0] = p0;
        cur_pts[1] = p1;
        cur_pts[2] = p2;
        cur_pts[3] = p3;
    endtask

    function automatic int clip16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic point_t make_point(input int x, input int y);
        point_t p;
        p.x = q88_t'(x);
        p.y = q88_t'(y);
        return p;
    endfunction

    // Pick a raw value: full range, inside the clamp window, or close to a
    // breakpoint so the interpolation edges get hit.
    function automatic logic [15:0] pick_raw();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = $signed(16'($urandom));
        else if (sel < 7 && cur_min <= cur_max)
            v = clip16(int'(cur_min) + int'($urandom_range(0, int'(cur_max) - int'(cur_min)))
                       + int'($urandom_range(0, 8)) - 4);
        else
            v = clip16(int'(cur_pts[$urandom_range(0, NUM_SLOTS-1)].x)
                       + int'($urandom_range(0, 6)) - 3);
        return 16'(v);
    endfunction

    // Random curve and bounds. Mostly ascending breakpoints (the ones that
    // reach the interpolation); also short curves, duplicate x, unordered
    // points and mapping disabled.
    task automatic random_cfg();
        int         kind;
        int         bkind;
        int         lo;
        int         hi;
        int         tmp;
        int         base;
        int         spread;
        int         xs [NUM_SLOTS];
        int         ys [NUM_SLOTS];
        logic       en;
        logic [2:0] cnt;
        kind  = $urandom_range(0, 9);
        bkind = $urandom_range(0, 5);
        lo = $signed(16'($urandom));
        hi = $signed(16'($urandom));
        if (bkind == 0) begin
            lo = -32768;
            hi = 32767;
        end else if (bkind == 1) begin
            // crossed bounds: the lower bound wins
            if (lo < hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
        end else if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        base   = $signed(16'($urandom));
        spread = $urandom_range(1, 3000);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (kind < 3)
                xs[k] = $signed(16'($urandom));
            else
                xs[k] = clip16(base + int'($urandom_range(0, spread)));
            case ($urandom_range(0, 7))
                0:       ys[k] = -32768;
                1:       ys[k] = 32767;
                default: ys[k] = $signed(16'($urandom));
            endcase
        end
        if (kind != 7) begin
            for (int a = 0; a < NUM_SLOTS - 1; a++)
                for (int b = 0; b < NUM_SLOTS - 1 - a; b++)
                    if (xs[b] > xs[b+1]) begin
                        tmp     = xs[b];
                        xs[b]   = xs[b+1];
                        xs[b+1] = tmp;
                    end
        end
        if (kind == 8)
            xs[2] = xs[1];
        en  = (kind != 9);
        if (kind == 6)
            cnt = 3'($urandom_range(0, 1));
        else if ($urandom_range(0, 4) == 0)
            cnt = 3'($urandom_range(5, 7));
        else
            cnt = 3'($urandom_range(2, 4));
        set_cfg(q88_t'(lo), q88_t'(hi), en, cnt,
                make_point(xs[0], ys[0]), make_point(xs[1], ys[1]),
                make_point(xs[2], ys[2]), make_point(xs[3], ys[3]));
    endtask

    // Send a fixed list back to back, then drop tvalid
    task automatic send_list(input logic [15:0] vals [$]);
        foreach (vals[k])
            send_item(vals[k]);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Send n random items in bursts of random length with random gaps;
    // some bursts cover the whole phase with no gap at all.
    task automatic drive_items(input int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n) begin
            burst = ($urandom_range(0, 5) == 0) ? n : int'($urandom_range(1, 24));
            for (int j = 0; j < burst && sent < n; j++) begin
                send_item(pick_raw());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 16'($urandom);   // noise on the bus while idle
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        wait (pending_count == 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        long_hold_req = 1'b0;
        cur_min       = '0;
        cur_max       = q88_t'(256);
        for (int k = 0; k < NUM_SLOTS; k++)
            cur_pts[k] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: clamp to [0, 1.0], mapping off
        send_list('{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'h0101, 16'hffff});
        wait_drained();

        // Full window, four ascending points spanning the whole x range
        set_cfg(q88_t'(-32768), q88_t'(32767), 1'b1, 3'd4,
                make_point(-32768, 32767), make_point(-256, -32768),
                make_point(256, 32767), make_point(32767, -32768));
        send_list('{16'h8000, 16'h8001, 16'hff00, 16'h0000, 16'h03e8, 16'h7fff});
        wait_drained();

        // Crossed bounds with an empty curve
        set_cfg(q88_t'(100), q88_t'(-100), 1'b1, 3'd0,
                make_point(0, 0), make_point(0, 0), make_point(0, 0), make_point(0, 0));
        send_list('{16'h7fff, 16'h8000, 16'h0000});
        wait_drained();

        // Single point
        set_cfg(q88_t'(-32768), q88_t'(32767), 1'b1, 3'd1,
                make_point(300, -500), make_point(0, 0),
                make_point(0, 0), make_point(0, 0));
        send_list('{16'hfffb, 16'h3039});
        wait_drained();

        // Count above the maximum, two breakpoints sharing an x
        set_cfg(q88_t'(-32768), q88_t'(32767), 1'b1, 3'd7,
                make_point(-512, 10), make_point(0, -20),
                make_point(0, 700), make_point(512, -9));
        send_list('{16'h0000, 16'hff9c, 16'h0064, 16'h0258});
        wait_drained();

        // Unordered breakpoints
        set_cfg(q88_t'(-32768), q88_t'(32767), 1'b1, 3'd4,
                make_point(-100, 1), make_point(-300, 2),
                make_point(400, 3), make_point(50, 4));
        send_list('{16'h0000, 16'h003c, 16'hff38});
        wait_drained();

        // Random phases; one of them runs under a long receiver hold-off so
        // the pipe fills and the input stalls
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_cfg();
            if (ph == 4)
                long_hold_req = 1'b1;
            drive_items(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ clamp_piecewise_linear_map.f @@
hw/rtl/cpl_pkg.sv
hw/rtl/cpl_regs.sv
hw/rtl/cpl_front.sv
hw/rtl/cpl_div_step.sv
hw/rtl/clamp_piecewise_linear_map.sv
hw/rtl/cpl_checker.sv
sim/clamp_piecewise_linear_map_checker.sv
sim/clamp_piecewise_linear_map_tb.sv
